// ===== src/gn3d_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// gn3d_pkg: shared types for the gradient noise block
// Controller command and datapath status structures.
// ---------------------------------------------------------------------------
package gn3d_pkg;

	typedef struct packed {
		logic load_in;   // capture input item, start fades
		logic tbl_wr;    // write permutation entry
		logic rd1;       // corner hash read 1
		logic rd2;       // corner hash read 2
		logic rd3;       // corner hash read 3
		logic grad;      // corner gradient, stored per corner
		logic fin;       // final blend and saturate
		logic [2:0] crn; // corner index
	} gn3d_cmd_t;

	typedef struct packed {
		logic is_eval;
	} gn3d_sts_t;

	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_EVAL = 1'b1;

endpackage

// ===== src/gradient_noise_3d.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// gradient_noise_3d: improved 3-D gradient noise
// Channel   Dir  Contents
// s_axis    in   tdata {coord_z,coord_y,coord_x,table_value,table_index}, tuser cmd
// m_axis    out  tdata noise_value
// apb       in   repeat_mask at 0x0
// Load: accept, then a table write. Evaluate: accept, eight corners, each of
// three chained permutation reads plus a gradient, then a blend wait, a
// saturate step and an output step.
// Reset clears control only; the permutation table must be loaded first.
// One item at a time; a held result stalls the next evaluate only.
// ---------------------------------------------------------------------------
module gradient_noise_3d
	import gn3d_pkg::*;
#(
	parameter int TABLE_SIZE = 256,
	parameter int FRAC_BITS  = 16
)(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [111:0] s_axis_tdata, // table_index, table_value, x, y, z
	input  logic         s_axis_tuser, // cmd
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [23:0]  m_axis_tdata, // noise_value
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic         paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready
);
	logic [7:0] mask_q;
	logic in_fire, in_rdy, out_load;
	gn3d_cmd_t cmd;
	gn3d_sts_t sts;
	logic signed [17:0] res;
	logic ov_q;
	logic [17:0] od_q;

	assign pready = 1'b1;
	assign prdata = paddr ? 32'd0 : {24'd0, mask_q};
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) mask_q <= 8'hFF;
		else if (psel && penable && pwrite && !paddr) mask_q <= pwdata[7:0];
	end

	assign s_axis_tready = in_rdy;
	assign in_fire = s_axis_tvalid && in_rdy;

	gn3d_ctrl u_ctrl (
		.clk, .arst_n, .in_fire, .sts, .out_busy(ov_q && !m_axis_tready),
		.in_rdy, .cmd, .out_load
	);

	gn3d_dp #(.TABLE_SIZE(TABLE_SIZE), .FRAC_BITS(FRAC_BITS)) u_dp (
		.clk, .arst_n, .cmd, .mask(mask_q), .in_cmd(s_axis_tuser),
		.in_idx(s_axis_tdata[7:0]), .in_val(s_axis_tdata[15:8]),
		.in_x(s_axis_tdata[47:16]), .in_y(s_axis_tdata[79:48]),
		.in_z(s_axis_tdata[111:80]), .sts, .result(res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) ov_q <= 1'b0;
		else if (out_load) ov_q <= 1'b1;
		else if (m_axis_tready) ov_q <= 1'b0;
	end
	always_ff @(posedge clk) if (out_load) od_q <= res;

	assign m_axis_tvalid = ov_q;
	assign m_axis_tdata = {6'd0, od_q};
endmodule

// ===== src/gn3d_ctrl.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// gn3d_ctrl: sequencer
// Steps eight corners through three table reads and a gradient each.
// ---------------------------------------------------------------------------
module gn3d_ctrl
	import gn3d_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_fire,
	input  gn3d_sts_t sts,
	input  logic      out_busy,
	output logic      in_rdy,
	output gn3d_cmd_t cmd,
	output logic      out_load
);
	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_DISP = 3'd1;
	localparam logic [2:0] ST_RD2  = 3'd2;
	localparam logic [2:0] ST_RD3  = 3'd3;
	localparam logic [2:0] ST_GRAD = 3'd4;
	localparam logic [2:0] ST_FIN  = 3'd5;
	localparam logic [2:0] ST_OUT  = 3'd6;
	localparam logic [2:0] ST_FADE = 3'd7;

	logic [2:0] state_q, state_d;
	logic [2:0] crn_q;
	logic [2:0] fcnt_q;

	assign in_rdy = (state_q == ST_IDLE);

	always_comb begin
		cmd = '0;
		cmd.crn = crn_q;
		cmd.load_in = in_fire;
		out_load = 1'b0;
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (in_fire) state_d = ST_DISP;
			ST_DISP: begin
				if (sts.is_eval) begin
					cmd.rd1 = 1'b1;
					state_d = ST_RD2;
				end else begin
					cmd.tbl_wr = 1'b1;
					state_d = ST_IDLE;
				end
			end
			ST_RD2: begin
				cmd.rd2 = 1'b1;
				state_d = ST_RD3;
			end
			ST_RD3: begin
				cmd.rd3 = 1'b1;
				state_d = ST_GRAD;
			end
			ST_GRAD: begin
				cmd.grad = 1'b1;
				state_d = (crn_q == 3'd7) ? ST_FADE : ST_DISP;
			end
			ST_FADE: if (fcnt_q == 3'd0) state_d = ST_FIN;
			ST_FIN: begin
				cmd.fin = 1'b1;
				state_d = ST_OUT;
			end
			ST_OUT: begin
				if (!out_busy) begin
					out_load = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			crn_q <= '0;
			fcnt_q <= '0;
		end else begin
			state_q <= state_d;
			if (in_fire) crn_q <= '0;
			else if (cmd.grad) crn_q <= crn_q + 3'd1;
			if (state_q == ST_GRAD) fcnt_q <= 3'd3;
			else if (fcnt_q != 3'd0) fcnt_q <= fcnt_q - 3'd1;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rd2 |-> $past(cmd.rd1)) else $error("rd2 without rd1");
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.grad |-> $past(cmd.rd3)) else $error("grad without rd3");
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.fin |=> !in_rdy) else $error("ready during output");
endmodule

// ===== src/gn3d_dp.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// gn3d_dp: datapath
// Permutation memory, corner hashing, gradients, fades and blending.
// ---------------------------------------------------------------------------
module gn3d_dp
	import gn3d_pkg::*;
#(
	parameter int TABLE_SIZE = 256,
	parameter int FRAC_BITS  = 16
)(
	input  logic               clk,
	input  logic               arst_n,
	input  gn3d_cmd_t          cmd,
	input  logic [7:0]         mask,
	input  logic               in_cmd,
	input  logic [7:0]         in_idx,
	input  logic [7:0]         in_val,
	input  logic signed [31:0] in_x,
	input  logic signed [31:0] in_y,
	input  logic signed [31:0] in_z,
	output gn3d_sts_t          sts,
	output logic signed [17:0] result
);
	localparam int AW = $clog2(TABLE_SIZE);
	localparam int FB = FRAC_BITS;
	localparam int VW = FB + 3;   // corner values, blends: |v| < 4*2^FB
	localparam int PW = 2 * FB + 8;
	localparam int SH = (FB > 16) ? FB - 16 : 0;
	localparam int SL = (FB < 16) ? 16 - FB : 0;

	logic [7:0] perm_q [TABLE_SIZE];
	logic [7:0] rdat_q;
	logic       cmd_q;
	logic [7:0] idx_q, val_q;
	logic [7:0] i0_q, i1_q, j0_q, j1_q, k0_q, k1_q;
	logic [FB-1:0] fx_q, fy_q, fz_q;
	logic [FB:0] fu_q, fv_q, fw_q;
	logic signed [VW-1:0] acc_q [8];
	logic signed [17:0] res_q;
	logic [7:0] ci, cj, ck;
	logic [AW-1:0] raddr;

	assign sts.is_eval = cmd_q;
	assign result = res_q;
	assign ci = cmd.crn[0] ? i1_q : i0_q;
	assign cj = cmd.crn[1] ? j1_q : j0_q;
	assign ck = cmd.crn[2] ? k1_q : k0_q;

	always_comb begin
		logic [8:0] s;
		s = 9'd0;
		if (cmd.rd1) s = {1'b0, ci};
		else if (cmd.rd2) s = {1'b0, rdat_q} + {1'b0, cj};
		else s = {1'b0, rdat_q} + {1'b0, ck};
		raddr = s[AW-1:0];
	end

	always_ff @(posedge clk) begin
		if (cmd.tbl_wr && ({24'd0, idx_q} < TABLE_SIZE))
			perm_q[idx_q[AW-1:0]] <= val_q;
		if (cmd.rd1 || cmd.rd2 || cmd.rd3)
			rdat_q <= perm_q[raddr];
	end

	// fade, computed serially, one axis after another
	function automatic logic [FB+4:0] mulq(input logic [FB+4:0] a, input logic [FB+4:0] b);
		logic [2*FB+9:0] p;
		p = a * b;
		return p[2*FB+4:FB];
	endfunction

	logic [1:0] ax_q;
	logic [2:0] fs_q;
	logic [FB+4:0] ta_q, tb_q, t2_q;
	logic [FB:0] fsel;
	always_comb begin
		case (ax_q)
			2'd0: fsel = {1'b0, fx_q};
			2'd1: fsel = {1'b0, fy_q};
			default: fsel = {1'b0, fz_q};
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fs_q <= '0;
			ax_q <= '0;
		end else if (cmd.load_in) begin
			fs_q <= 3'd1;
			ax_q <= '0;
		end else if (fs_q != 3'd0) begin
			case (fs_q)
				3'd1: fs_q <= 3'd2;
				3'd2: fs_q <= 3'd3;
				3'd3: fs_q <= 3'd4;
				3'd4: fs_q <= 3'd5;
				default: begin
					if (ax_q == 2'd2) fs_q <= 3'd0;
					else begin
						fs_q <= 3'd1;
						ax_q <= ax_q + 2'd1;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		logic [FB+4:0] a;
		a = (FB+5)'(15) << FB;
		a = a - (FB+5)'(6) * {4'd0, fsel};
		case (fs_q)
			3'd1: ta_q <= mulq(a, {4'd0, fsel});
			3'd2: begin
				tb_q <= ((FB+5)'(10) << FB) - ta_q;
				t2_q <= mulq({4'd0, fsel}, {4'd0, fsel});
			end
			3'd3: t2_q <= mulq(t2_q, {4'd0, fsel});
			3'd4: ta_q <= mulq(t2_q, tb_q);
			3'd5: begin
				case (ax_q)
					2'd0: fu_q <= ta_q[FB:0];
					2'd1: fv_q <= ta_q[FB:0];
					default: fw_q <= ta_q[FB:0];
				endcase
			end
			default: ;
		endcase
	end

	// input capture
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) cmd_q <= CMD_LOAD;
		else if (cmd.load_in) cmd_q <= in_cmd;
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			idx_q <= in_idx;
			val_q <= in_val;
			i0_q <= in_x[FB+7:FB] & mask;
			i1_q <= (in_x[FB+7:FB] + 8'd1) & mask;
			j0_q <= in_y[FB+7:FB] & mask;
			j1_q <= (in_y[FB+7:FB] + 8'd1) & mask;
			k0_q <= in_z[FB+7:FB] & mask;
			k1_q <= (in_z[FB+7:FB] + 8'd1) & mask;
			fx_q <= in_x[FB-1:0];
			fy_q <= in_y[FB-1:0];
			fz_q <= in_z[FB-1:0];
		end
	end

	// gradient
	logic [3:0] h;
	logic signed [VW-1:0] gxv, gyv, gzv, gu, gv, gc;
	always_comb begin
		h = rdat_q[3:0];
		gxv = cmd.crn[0] ? VW'($signed({1'b0, fx_q})) - (VW'(1) <<< FB)
			: VW'($signed({1'b0, fx_q}));
		gyv = cmd.crn[1] ? VW'($signed({1'b0, fy_q})) - (VW'(1) <<< FB)
			: VW'($signed({1'b0, fy_q}));
		gzv = cmd.crn[2] ? VW'($signed({1'b0, fz_q})) - (VW'(1) <<< FB)
			: VW'($signed({1'b0, fz_q}));
		gu = (h < 4'd8) ? gxv : gyv;
		gv = (h < 4'd4) ? gyv : ((h == 4'd12 || h == 4'd14) ? gxv : gzv);
		gc = (h[0] ? -gu : gu) + (h[1] ? -gv : gv);
	end

	always_ff @(posedge clk) begin
		if (cmd.grad) acc_q[cmd.crn] <= gc;
	end

	// blend tree after the corners, x then y level registered, z combinational
	function automatic logic signed [VW-1:0] lerp(input logic signed [VW-1:0] a,
		input logic signed [VW-1:0] b, input logic [FB:0] w);
		logic signed [PW-1:0] p;
		p = PW'(b - a) * $signed({1'b0, w});
		return a + VW'(p >>> FB);
	endfunction

	logic [1:0] bl_q;
	logic signed [VW-1:0] y_q [4];
	logic signed [VW-1:0] z_q [2];
	logic signed [VW-1:0] r;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) bl_q <= '0;
		else if (cmd.grad && cmd.crn == 3'd7) bl_q <= 2'd1;
		else if (bl_q == 2'd1) bl_q <= 2'd2;
		else if (bl_q == 2'd2) bl_q <= 2'd0;
	end

	always_ff @(posedge clk) begin
		if (bl_q == 2'd1) begin
			for (int n = 0; n < 4; n++)
				y_q[n] <= lerp(acc_q[2*n], acc_q[2*n+1], fu_q);
		end
		if (bl_q == 2'd2) begin
			z_q[0] <= lerp(y_q[0], y_q[1], fv_q);
			z_q[1] <= lerp(y_q[2], y_q[3], fv_q);
		end
	end

	always_comb r = lerp(z_q[0], z_q[1], fw_q);

	always_ff @(posedge clk) begin
		logic signed [VW+16:0] s;
		if (cmd.fin) begin
			s = (VW+17)'(r >>> SH) <<< SL;
			if (s > 131071) res_q <= 18'sd131071;
			else if (s < -131072) res_q <= -18'sd131072;
			else res_q <= s[17:0];
		end
	end
endmodule
